@@ rtl/led_cube_layer_scanner_top_assert.svh @@
// Assertion helpers used by the scanner's back end, lcls_back.
// Both expect a clock named clock and a synchronous reset named reset.
`ifndef LED_CUBE_LAYER_SCANNER_TOP_ASSERT_SVH
`define LED_CUBE_LAYER_SCANNER_TOP_ASSERT_SVH

// Same-cycle implication.
`define LCLS_ASSERT_IMPLY(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication.
`define LCLS_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ rtl/lcls_pkg.sv @@
package lcls_pkg;

   localparam int CUBE_SIDE_DEFAULT   = 4;
   localparam int QUEUE_DEPTH_DEFAULT = 2;

   localparam int OP_W          = 2;
   localparam int COORD_W       = 2;
   localparam int LAYER_DRIVE_W = 4;

   typedef enum logic [OP_W-1:0] {
      OP_WRITE = 2'd0,
      OP_TICK  = 2'd1,
      OP_CLEAR = 2'd2
   } op_type;

   typedef enum logic [1:0] {
      CMD_WRITE,
      CMD_TICK,
      CMD_CLEAR
   } cmd_kind_type;

   typedef struct packed {
      cmd_kind_type       kind;
      logic [COORD_W-1:0] layer;
      logic [COORD_W-1:0] row;
      logic [COORD_W-1:0] col;
      logic               lit;
   } cmd_type;

endpackage

@@ rtl/lcls_if.sv @@
interface lcls_req_if;
   logic                         valid;
   logic                         ready;
   logic [lcls_pkg::OP_W-1:0]    operation;
   logic [lcls_pkg::COORD_W-1:0] col;
   logic [lcls_pkg::COORD_W-1:0] row;
   logic [lcls_pkg::COORD_W-1:0] layer;
   logic                         lit;

   modport source (output valid, output operation, output col, output row,
                   output layer, output lit, input ready);
   modport sink   (input valid, input operation, input col, input row,
                   input layer, input lit, output ready);
endinterface

interface lcls_rsp_if;
   logic                               valid;
   logic                               ready;
   logic                               serial_bit;
   logic                               latch;
   logic [lcls_pkg::LAYER_DRIVE_W-1:0] layer_drive;

   modport source (output valid, output serial_bit, output latch,
                   output layer_drive, input ready);
   modport sink   (input valid, input serial_bit, input latch,
                   input layer_drive, output ready);
endinterface

@@ rtl/lcls_front.sv @@
module lcls_front #(
   parameter int CUBE_SIDE = lcls_pkg::CUBE_SIDE_DEFAULT
) (
   lcls_req_if.sink          req,
   input  logic              queue_full,
   output logic              push,
   output lcls_pkg::cmd_type push_cmd
);

   logic in_cube;
   logic keep;

   assign req.ready = !queue_full;

   // Writes outside a small cube are dropped here, never queued.
   assign in_cube = (int'(req.col) < CUBE_SIDE) && (int'(req.row) < CUBE_SIDE)
                    && (int'(req.layer) < CUBE_SIDE);

   always_comb begin
      keep           = 1'b0;
      push_cmd.kind  = lcls_pkg::CMD_WRITE;
      push_cmd.layer = req.layer;
      push_cmd.row   = req.row;
      push_cmd.col   = req.col;
      push_cmd.lit   = req.lit;
      case (req.operation)
         lcls_pkg::OP_WRITE: begin
            keep          = in_cube;
            push_cmd.kind = lcls_pkg::CMD_WRITE;
         end
         lcls_pkg::OP_TICK: begin
            keep          = 1'b1;
            push_cmd.kind = lcls_pkg::CMD_TICK;
         end
         lcls_pkg::OP_CLEAR: begin
            keep          = 1'b1;
            push_cmd.kind = lcls_pkg::CMD_CLEAR;
         end
         default: begin
            keep          = 1'b0;
            push_cmd.kind = lcls_pkg::CMD_WRITE;
         end
      endcase
   end

   assign push = req.valid && req.ready && keep;

endmodule

@@ rtl/lcls_cmd_fifo.sv @@
module lcls_cmd_fifo #(
   parameter int DEPTH = lcls_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  lcls_pkg::cmd_type push_cmd,
   output logic              full,
   input  logic              pop,
   output lcls_pkg::cmd_type head,
   output logic              empty
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   lcls_pkg::cmd_type entry_ff [DEPTH];
   logic [PTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]  count_ff, count_in;

   assign full  = (count_ff == CNT_W'(DEPTH));
   assign empty = (count_ff == '0);
   assign head  = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

@@ rtl/lcls_back.sv @@
`include "led_cube_layer_scanner_top_assert.svh"

module lcls_back #(
   parameter int CUBE_SIDE = lcls_pkg::CUBE_SIDE_DEFAULT
) (
   input  logic              clock,
   input  logic              reset,
   input  lcls_pkg::cmd_type cmd,
   input  logic              cmd_empty,
   output logic              pop,
   lcls_rsp_if.source        rsp
);

   localparam int PLANE = CUBE_SIDE * CUBE_SIDE;
   localparam int LW    = $clog2(CUBE_SIDE);
   localparam int PW    = $clog2(PLANE);

   typedef enum logic {
      ST_IDLE,
      ST_SHIFT
   } state_type;

   state_type  state_ff, state_in;
   // One row per layer; a layer whose bit is clear in row_ok reads as dark.
   logic [PLANE-1:0] store_ff [CUBE_SIDE];
   logic [PLANE-1:0] store_in [CUBE_SIDE];
   logic [CUBE_SIDE-1:0] row_ok_ff, row_ok_in;
   logic [PLANE-1:0] shift_ff, shift_in;
   logic [PW-1:0]    cnt_ff, cnt_in;
   logic [LW-1:0]    scan_ff, scan_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic             bit_ff, bit_in;
   logic             latch_ff, latch_in;
   logic [lcls_pkg::LAYER_DRIVE_W-1:0] drive_ff, drive_in;

   logic [LW-1:0]    rd_layer;
   logic [PLANE-1:0] rd_row;
   logic [PLANE-1:0] wr_row;
   logic [PW-1:0]    pos;
   logic [lcls_pkg::LAYER_DRIVE_W-1:0] scan_drive;
   logic             load_out;
   logic             last;

   assign rd_layer = (cmd.kind == lcls_pkg::CMD_WRITE) ? LW'(cmd.layer) : scan_ff;
   assign rd_row   = row_ok_ff[rd_layer] ? store_ff[rd_layer] : '0;
   assign pos      = PW'(int'(cmd.row) * CUBE_SIDE + int'(cmd.col));
   assign load_out = (state_ff == ST_SHIFT) && (!rsp_valid_ff || rsp.ready);
   assign last     = (cnt_ff == PW'(PLANE - 1));

   always_comb begin
      for (int i = 0; i < lcls_pkg::LAYER_DRIVE_W; i++) begin
         scan_drive[i] = (int'(scan_ff) == i);
      end
   end

   always_comb begin
      state_in     = state_ff;
      store_in     = store_ff;
      row_ok_in    = row_ok_ff;
      shift_in     = shift_ff;
      cnt_in       = cnt_ff;
      scan_in      = scan_ff;
      rsp_valid_in = rsp_valid_ff;
      bit_in       = bit_ff;
      latch_in     = latch_ff;
      drive_in     = drive_ff;
      wr_row       = rd_row;
      pop          = 1'b0;

      if (rsp_valid_ff && rsp.ready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         ST_IDLE: begin
            if (!cmd_empty) begin
               pop = 1'b1;
               case (cmd.kind)
                  lcls_pkg::CMD_WRITE: begin
                     wr_row[pos]         = cmd.lit;
                     store_in[rd_layer]  = wr_row;
                     row_ok_in[rd_layer] = 1'b1;
                  end
                  lcls_pkg::CMD_CLEAR: begin
                     row_ok_in = '0;
                  end
                  lcls_pkg::CMD_TICK: begin
                     shift_in = rd_row;
                     cnt_in   = '0;
                     state_in = ST_SHIFT;
                  end
                  default: begin
                     pop = 1'b1;
                  end
               endcase
            end
         end
         ST_SHIFT: begin
            // Highest position first; latch and layer drive ride on the last bit.
            if (load_out) begin
               rsp_valid_in = 1'b1;
               bit_in       = shift_ff[PLANE-1];
               shift_in     = shift_ff << 1;
               latch_in     = last;
               drive_in     = last ? scan_drive : '0;
               cnt_in       = cnt_ff + 1'b1;
               if (last) begin
                  scan_in  = (scan_ff == LW'(CUBE_SIDE - 1)) ? '0 : scan_ff + 1'b1;
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         row_ok_ff    <= '0;
         scan_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         row_ok_ff    <= row_ok_in;
         scan_ff      <= scan_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      store_ff <= store_in;
      shift_ff <= shift_in;
      cnt_ff   <= cnt_in;
      bit_ff   <= bit_in;
      latch_ff <= latch_in;
      drive_ff <= drive_in;
   end

   assign rsp.valid       = rsp_valid_ff;
   assign rsp.serial_bit  = bit_ff;
   assign rsp.latch       = latch_ff;
   assign rsp.layer_drive = drive_ff;

   `LCLS_ASSERT_IMPLY(a_pop_only_idle, pop, state_ff == ST_IDLE, "command taken mid-scan")
   `LCLS_ASSERT_IMPLY(a_drive_only_on_latch, rsp_valid_ff && !latch_ff, drive_ff == '0, "layer drive on before last bit")
   `LCLS_ASSERT_NEXT(a_last_bit_ends_scan, load_out && last, state_ff == ST_IDLE && scan_ff != $past(scan_ff), "scan did not close after last bit")
   `LCLS_ASSERT_NEXT(a_tick_starts_scan, pop && cmd.kind == lcls_pkg::CMD_TICK, state_ff == ST_SHIFT && cnt_ff == '0, "tick did not start a scan")

endmodule

@@ rtl/led_cube_layer_scanner_top.sv @@
// Channel | Direction | Carries
// req_bus | in        | operation, col, row, layer, lit (write, tick, clear)
// rsp_bus | out       | serial_bit, latch, layer_drive (one item per bit)
//
// Writes and clears are taken by the back end while it is idle; a tick loads the
// layer, then gives CUBE_SIDE*CUBE_SIDE items, one per cycle while rsp_bus is ready,
// paced by the single output register.
// A two-entry command queue lets requests be taken while a scan is shifting out.
// Reset is synchronous; the voxel store reads dark at once through per-layer valid bits.
// A stalled rsp_bus holds the current bit and freezes the scan; req_bus stalls when full.
module led_cube_layer_scanner_top #(
   parameter int CUBE_SIDE   = lcls_pkg::CUBE_SIDE_DEFAULT,
   parameter int QUEUE_DEPTH = lcls_pkg::QUEUE_DEPTH_DEFAULT
) (
   input logic        clock,
   input logic        reset,
   lcls_req_if.sink   req_bus,
   lcls_rsp_if.source rsp_bus
);

   logic              push;
   lcls_pkg::cmd_type push_cmd;
   logic              queue_full;
   logic              pop;
   lcls_pkg::cmd_type head;
   logic              queue_empty;

   lcls_front #(
      .CUBE_SIDE (CUBE_SIDE)
   ) u_front (
      .req        (req_bus),
      .queue_full (queue_full),
      .push       (push),
      .push_cmd   (push_cmd)
   );

   lcls_cmd_fifo #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_cmd (push_cmd),
      .full     (queue_full),
      .pop      (pop),
      .head     (head),
      .empty    (queue_empty)
   );

   lcls_back #(
      .CUBE_SIDE (CUBE_SIDE)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .cmd       (head),
      .cmd_empty (queue_empty),
      .pop       (pop),
      .rsp       (rsp_bus)
   );

endmodule
